// File: rtl/core/tpsdg_pkg.sv
`default_nettype none

package tpsdg_pkg;

  // Table size and the widths that follow from the fixed field widths.
  localparam int TABLE_ENTRIES = 180;
  localparam int INDEX_W       = 8;
  localparam int DUTY_W        = 8;
  localparam int PERIOD_W      = 8;
  localparam int TICK_W        = 9;
  localparam int SECTOR_W      = 3;
  localparam int AMP_W         = 8;
  localparam int PROD_W        = DUTY_W + AMP_W;

  // Sector numbering runs from zero up to the last sector and wraps.
  localparam logic [SECTOR_W-1:0] SECTOR_LAST = 3'd5;

  // Configuration port layout.
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;
  localparam logic [PADDR_W-1:0] ADDR_AMPLITUDE = 3'd0;
  localparam logic [AMP_W-1:0]   AMP_RESET      = 8'd255;

  // Phase index reset values, one third of the table apart.
  localparam logic [INDEX_W-1:0] INDEX_V_RESET = INDEX_W'(TABLE_ENTRIES / 3);
  localparam logic [INDEX_W-1:0] INDEX_U_RESET = INDEX_W'(2 * (TABLE_ENTRIES / 3));
  localparam logic [INDEX_W-1:0] INDEX_LAST    = INDEX_W'(TABLE_ENTRIES - 1);

  // Fixed point constants for building the sine table (Q60).
  localparam logic [63:0] Q60_ONE     = 64'h1000_0000_0000_0000;
  localparam logic [63:0] HALF_PI_Q60 = 64'h1921_FB54_442D_1846;

  typedef logic [DUTY_W-1:0] sine_table_t [TABLE_ENTRIES];

  // Step a phase index by one, wrapping at the end of the table.
  function automatic logic [INDEX_W-1:0] bump_index(input logic [INDEX_W-1:0] idx);
    return (idx == INDEX_LAST) ? '0 : idx + INDEX_W'(1);
  endfunction

  // (a * b) >> 60 for operands below 2^62, built from 32 bit partial products.
  function automatic logic [63:0] qmul(input logic [63:0] a, input logic [63:0] b);
    logic [63:0] ah;
    logic [63:0] al;
    logic [63:0] bh;
    logic [63:0] bl;
    logic [63:0] lo;
    logic [63:0] mid;
    logic [63:0] hi;
    logic [63:0] sumlo;
    logic [63:0] carry;
    ah    = a >> 32;
    al    = a & 64'h0000_0000_FFFF_FFFF;
    bh    = b >> 32;
    bl    = b & 64'h0000_0000_FFFF_FFFF;
    lo    = al * bl;
    mid   = ah * bl + al * bh;
    hi    = ah * bh;
    sumlo = lo + (mid << 32);
    carry = (sumlo < lo) ? 64'd1 : 64'd0;
    hi    = hi + (mid >> 32) + carry;
    return (hi << 4) | (sumlo >> 60);
  endfunction

  // Divide by n * (n + 1), the Taylor denominator step for term number n.
  function automatic logic [63:0] div_pair(input logic [63:0] x, input logic [4:0] n);
    logic [63:0] y;
    case (n)
      5'd1:    y = x / 2;
      5'd2:    y = x / 6;
      5'd3:    y = x / 12;
      5'd4:    y = x / 20;
      5'd5:    y = x / 30;
      5'd6:    y = x / 42;
      5'd7:    y = x / 56;
      5'd8:    y = x / 72;
      5'd9:    y = x / 90;
      5'd10:   y = x / 110;
      5'd11:   y = x / 132;
      5'd12:   y = x / 156;
      5'd13:   y = x / 182;
      5'd14:   y = x / 210;
      5'd15:   y = x / 240;
      5'd16:   y = x / 272;
      5'd17:   y = x / 306;
      5'd18:   y = x / 342;
      5'd19:   y = x / 380;
      5'd20:   y = x / 420;
      5'd21:   y = x / 462;
      5'd22:   y = x / 506;
      5'd23:   y = x / 552;
      5'd24:   y = x / 600;
      5'd25:   y = x / 650;
      5'd26:   y = x / 702;
      5'd27:   y = x / 756;
      5'd28:   y = x / 812;
      default: y = x;
    endcase
    return y;
  endfunction

  // Taylor series for sine (odd) or cosine (even) on the first quadrant.
  function automatic logic [63:0] series(input logic [63:0] th, input logic odd);
    logic [63:0] th2;
    logic [63:0] term;
    logic [63:0] acc;
    th2  = qmul(th, th);
    term = odd ? th : Q60_ONE;
    acc  = term;
    for (int k = 1; k <= 14; k++) begin
      term = div_pair(qmul(term, th2), odd ? 5'(2 * k) : 5'(2 * k - 1));
      if (k[0]) begin
        acc = acc - term;
      end else begin
        acc = acc + term;
      end
    end
    if (acc > Q60_ONE) begin
      acc = Q60_ONE;
    end
    return acc;
  endfunction

  // One raised sine entry, folded by quadrant so quarter points are exact.
  function automatic logic [DUTY_W-1:0] rom_entry(input int i);
    logic [31:0] q;
    logic [31:0] quad;
    logic [31:0] r;
    logic [63:0] th;
    logic [63:0] m;
    logic [63:0] u;
    logic [63:0] v;
    q    = 32'(4 * i);
    quad = q / TABLE_ENTRIES;
    r    = q % TABLE_ENTRIES;
    th   = (HALF_PI_Q60 / TABLE_ENTRIES) * 64'(r) +
           ((HALF_PI_Q60 % TABLE_ENTRIES) * 64'(r)) / TABLE_ENTRIES;
    m    = series(th, quad[0] == 1'b0);
    if (quad < 32'd2) begin
      u = Q60_ONE + m;
    end else begin
      u = Q60_ONE - m;
    end
    v = 64'd255 * (u >> 32) + ((64'd255 * (u & 64'h0000_0000_FFFF_FFFF)) >> 32);
    v = v >> 29;
    if (v > 64'd255) begin
      v = 64'd255;
    end
    return v[DUTY_W-1:0];
  endfunction

  function automatic sine_table_t build_sine_table();
    sine_table_t t;
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      t[i] = rom_entry(i);
    end
    return t;
  endfunction

  // Raised sine contents, worked out at elaboration.
  localparam sine_table_t SINE_TABLE = build_sine_table();

endpackage

`default_nettype wire

// File: rtl/core/three_phase_sine_duty_generator.sv
// Pipeline: an accepted request loads the tick, sector and index registers and the
// registered sine ROM read; the amplitude scaling is one stage, the output register.
// Throughput: one request per cycle while out_stall does not hold the output register.
// Reset (synchronous, rst high): counters, sector and held duties clear to zero, the
// phase indices return to zero, a third and two thirds of the table, amplitude to 255.
`default_nettype none

module three_phase_sine_duty_generator
  import tpsdg_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  // Tick requests.
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [PERIOD_W-1:0] speed_period,
  // Results.
  output logic                out_valid,
  input  logic                out_stall,
  output logic [DUTY_W-1:0]   duty_w,
  output logic [DUTY_W-1:0]   duty_v,
  output logic [DUTY_W-1:0]   duty_u,
  output logic                stepped,
  output logic [SECTOR_W-1:0] sector_now,
  // Configuration port.
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [PADDR_W-1:0]  paddr,
  input  logic [PDATA_W-1:0]  pwdata,
  output logic [PDATA_W-1:0]  prdata,
  output logic                pready
);

  logic [AMP_W-1:0]    amplitude;
  logic [TICK_W-1:0]   tick_count;
  logic [SECTOR_W-1:0] sector;
  logic [INDEX_W-1:0]  index_w;
  logic [INDEX_W-1:0]  index_v;
  logic [INDEX_W-1:0]  index_u;

  logic [TICK_W-1:0]   tick_inc;
  logic                step_now;
  logic [SECTOR_W-1:0] sector_inc;
  logic                adv_w;
  logic                adv_v;
  logic                adv_u;
  logic [INDEX_W-1:0]  index_w_next;
  logic [INDEX_W-1:0]  index_v_next;
  logic [INDEX_W-1:0]  index_u_next;
  logic [SECTOR_W-1:0] sector_next;

  logic                accept_in;
  logic                out_load;

  logic                s1_valid;
  logic                s1_stepped;
  logic [SECTOR_W-1:0] s1_sector;
  logic [DUTY_W-1:0]   rom_w;
  logic [DUTY_W-1:0]   rom_v;
  logic [DUTY_W-1:0]   rom_u;

  logic [PROD_W-1:0]   prod_w;
  logic [PROD_W-1:0]   prod_v;
  logic [PROD_W-1:0]   prod_u;
  logic [PROD_W:0]     quot_w;
  logic [PROD_W:0]     quot_v;
  logic [PROD_W:0]     quot_u;

  logic                cfg_write;

  // Pipeline handshake: the output register loads when it is empty or being taken.
  assign out_load  = !out_valid || !out_stall;
  assign in_stall  = s1_valid && !out_load;
  assign accept_in = in_valid && !in_stall;

  // Tick counting and the sector move for this request.
  assign tick_inc   = tick_count + TICK_W'(1);
  assign step_now   = tick_inc > {1'b0, speed_period};
  assign sector_inc = (sector == SECTOR_LAST) ? '0 : sector + SECTOR_W'(1);

  // The new sector decides which one or two phases advance.
  always_comb begin
    case (sector_inc)
      3'd0:    {adv_w, adv_v, adv_u} = 3'b100;
      3'd1:    {adv_w, adv_v, adv_u} = 3'b110;
      3'd2:    {adv_w, adv_v, adv_u} = 3'b010;
      3'd3:    {adv_w, adv_v, adv_u} = 3'b011;
      3'd4:    {adv_w, adv_v, adv_u} = 3'b001;
      default: {adv_w, adv_v, adv_u} = 3'b101;
    endcase
  end

  assign sector_next  = step_now ? sector_inc : sector;
  assign index_w_next = (step_now && adv_w) ? bump_index(index_w) : index_w;
  assign index_v_next = (step_now && adv_v) ? bump_index(index_v) : index_v;
  assign index_u_next = (step_now && adv_u) ? bump_index(index_u) : index_u;

  // Control state, updated on every accepted request.
  always_ff @(posedge clk) begin
    if (rst) begin
      tick_count <= '0;
      sector     <= '0;
      index_w    <= '0;
      index_v    <= INDEX_V_RESET;
      index_u    <= INDEX_U_RESET;
    end else if (accept_in) begin
      tick_count <= step_now ? '0 : tick_inc;
      sector     <= sector_next;
      index_w    <= index_w_next;
      index_v    <= index_v_next;
      index_u    <= index_u_next;
    end
  end

  // Sine ROM with registered read data, one read per phase.
  always_ff @(posedge clk) begin
    if (accept_in) begin
      rom_w      <= SINE_TABLE[index_w_next];
      rom_v      <= SINE_TABLE[index_v_next];
      rom_u      <= SINE_TABLE[index_u_next];
      s1_stepped <= step_now;
      s1_sector  <= sector_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept_in) begin
      s1_valid <= 1'b1;
    end else if (out_load) begin
      s1_valid <= 1'b0;
    end
  end

  // Scale by amplitude and divide by 255: floor(x/255) = (x + 1 + (x >> 8)) >> 8.
  assign prod_w = PROD_W'(rom_w) * PROD_W'(amplitude);
  assign prod_v = PROD_W'(rom_v) * PROD_W'(amplitude);
  assign prod_u = PROD_W'(rom_u) * PROD_W'(amplitude);
  assign quot_w = {1'b0, prod_w} + (PROD_W + 1)'(1) + (PROD_W + 1)'(prod_w >> DUTY_W);
  assign quot_v = {1'b0, prod_v} + (PROD_W + 1)'(1) + (PROD_W + 1)'(prod_v >> DUTY_W);
  assign quot_u = {1'b0, prod_u} + (PROD_W + 1)'(1) + (PROD_W + 1)'(prod_u >> DUTY_W);

  // Output register; its duty fields are the held duties between steps.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      duty_w     <= '0;
      duty_v     <= '0;
      duty_u     <= '0;
      sector_now <= '0;
      stepped    <= 1'b0;
    end else if (out_load) begin
      out_valid <= s1_valid;
      if (s1_valid) begin
        stepped    <= s1_stepped;
        sector_now <= s1_sector;
        if (s1_stepped) begin
          duty_w <= quot_w[PROD_W-1:DUTY_W];
          duty_v <= quot_v[PROD_W-1:DUTY_W];
          duty_u <= quot_u[PROD_W-1:DUTY_W];
        end
      end
    end
  end

  // Configuration register access.
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready && (paddr == ADDR_AMPLITUDE);

  always_ff @(posedge clk) begin
    if (rst) begin
      amplitude <= AMP_RESET;
    end else if (cfg_write) begin
      amplitude <= pwdata[AMP_W-1:0];
    end
  end

  assign prdata = (paddr == ADDR_AMPLITUDE) ? PDATA_W'(amplitude) : '0;

endmodule

`default_nettype wire

// File: rtl/core/tpsdg_checker.sv
`default_nettype none

module tpsdg_checker
  import tpsdg_pkg::*;
(
  input wire logic                clk,
  input wire logic                rst,
  input wire logic                out_valid,
  input wire logic                out_stall,
  input wire logic [DUTY_W-1:0]   duty_w,
  input wire logic [DUTY_W-1:0]   duty_v,
  input wire logic [DUTY_W-1:0]   duty_u,
  input wire logic                stepped,
  input wire logic [SECTOR_W-1:0] sector_now
);

  // A stalled result keeps its contents.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(duty_w) && $stable(duty_v) &&
      $stable(duty_u) && $stable(stepped) && $stable(sector_now))
    else $error("stalled result changed");

  // No result is pending right after reset.
  assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

  // Duties only change on a result that reports a step.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !stepped |-> $stable(duty_w) && $stable(duty_v) && $stable(duty_u))
    else $error("held duties changed without a step");

  // A freshly loaded stepping result moves the sector by exactly one.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && stepped && (!$past(out_valid) || !$past(out_stall)) |->
      ((($past(sector_now) == SECTOR_LAST) && (sector_now == '0)) ||
       (($past(sector_now) != SECTOR_LAST) &&
        (sector_now == $past(sector_now) + SECTOR_W'(1)))))
    else $error("sector did not advance by one on a step");

  // Sector number stays within range on every result.
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> sector_now <= SECTOR_LAST)
    else $error("sector out of range");

endmodule

bind three_phase_sine_duty_generator tpsdg_checker u_checker (.*);

`default_nettype wire

// File: dv/tb_three_phase_sine_duty_generator.sv
`timescale 1ns / 1ps

module tb_three_phase_sine_duty_generator;
  import tpsdg_pkg::*;

  // Fixed point constants for the independent sine table (Q60).
  localparam logic [63:0] ONE_FX     = 64'h1000_0000_0000_0000;
  localparam logic [63:0] HALF_PI_FX = 64'h1921_FB54_442D_1846;
  localparam int WATCHDOG_LIMIT      = 2000;
  localparam int LONG_HOLD_CYCLES    = 60;
  localparam int RANDOM_PER_PHASE    = 110;

  typedef struct packed {
    logic [DUTY_W-1:0]   w;
    logic [DUTY_W-1:0]   v;
    logic [DUTY_W-1:0]   u;
    logic                stepped;
    logic [SECTOR_W-1:0] sector;
  } duty_result_t;

  // Tracks the sector, phase indices and held duties, and checks each result.
  class sine_duty_predictor;
    logic [DUTY_W-1:0]   rom [TABLE_ENTRIES];
    logic [AMP_W-1:0]    amplitude;
    logic [TICK_W-1:0]   tick_count;
    logic [SECTOR_W-1:0] sector;
    logic [INDEX_W-1:0]  idx_w;
    logic [INDEX_W-1:0]  idx_v;
    logic [INDEX_W-1:0]  idx_u;
    logic [DUTY_W-1:0]   held_w;
    logic [DUTY_W-1:0]   held_v;
    logic [DUTY_W-1:0]   held_u;
    duty_result_t        expected_duties[$];
    int                  mismatches;
    int                  ticks;
    int                  steps;

    function new();
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
        rom[i] = raised_sine(i);
      end
      amplitude  = 8'd255;
      tick_count = '0;
      sector     = '0;
      idx_w      = '0;
      idx_v      = INDEX_W'(TABLE_ENTRIES / 3);
      idx_u      = INDEX_W'(2 * (TABLE_ENTRIES / 3));
      held_w     = '0;
      held_v     = '0;
      held_u     = '0;
      mismatches = 0;
      ticks      = 0;
      steps      = 0;
    endfunction

    // Q60 product, taken from the full 128 bit result.
    function logic [63:0] fx_mul(logic [63:0] a, logic [63:0] b);
      logic [127:0] p;
      p = {64'd0, a} * {64'd0, b};
      return p[123:60];
    endfunction

    // Taylor sum for sine (odd) or cosine (even) in the first quadrant.
    function logic [63:0] taylor(logic [63:0] th, bit odd);
      logic [63:0] th2;
      logic [63:0] term;
      logic [63:0] acc;
      logic [63:0] d;
      th2  = fx_mul(th, th);
      term = odd ? th : ONE_FX;
      acc  = term;
      for (int k = 1; k <= 14; k++) begin
        d    = odd ? 64'((2 * k) * (2 * k + 1)) : 64'((2 * k - 1) * (2 * k));
        term = fx_mul(term, th2) / d;
        acc  = (k % 2 == 1) ? acc - term : acc + term;
      end
      return (acc > ONE_FX) ? ONE_FX : acc;
    endfunction

    // Raised sine entry, folded by quadrant.
    function logic [DUTY_W-1:0] raised_sine(int i);
      logic [63:0]  q;
      logic [63:0]  quad;
      logic [63:0]  r;
      logic [63:0]  th;
      logic [63:0]  m;
      logic [63:0]  u;
      logic [127:0] scaled_u;
      q        = 64'(4 * i);
      quad     = q / 64'(TABLE_ENTRIES);
      r        = q % 64'(TABLE_ENTRIES);
      th       = (HALF_PI_FX / 64'(TABLE_ENTRIES)) * r +
                 ((HALF_PI_FX % 64'(TABLE_ENTRIES)) * r) / 64'(TABLE_ENTRIES);
      m        = taylor(th, quad[0] == 1'b0);
      u        = (quad < 64'd2) ? ONE_FX + m : ONE_FX - m;
      scaled_u = ({64'd0, u} * 128'd255) >> 61;
      return (scaled_u > 128'd255) ? 8'd255 : scaled_u[7:0];
    endfunction

    function logic [INDEX_W-1:0] bump(logic [INDEX_W-1:0] idx);
      return (int'(idx) + 1 == TABLE_ENTRIES) ? '0 : idx + 1'b1;
    endfunction

    function logic [DUTY_W-1:0] scaled(logic [INDEX_W-1:0] idx);
      logic [PROD_W-1:0] prod;
      prod = rom[idx] * amplitude;
      return DUTY_W'(prod / 255);
    endfunction

    // Advance the state for one accepted tick and queue its result.
    function void note_tick(logic [PERIOD_W-1:0] period);
      duty_result_t r;
      ticks++;
      tick_count = tick_count + 1'b1;
      r.stepped  = 1'b0;
      if (tick_count > {1'b0, period}) begin
        tick_count = '0;
        r.stepped  = 1'b1;
        steps++;
        sector = (sector == 3'd5) ? 3'd0 : sector + 1'b1;
        if (sector == 3'd0 || sector == 3'd1 || sector == 3'd5) idx_w = bump(idx_w);
        if (sector == 3'd1 || sector == 3'd2 || sector == 3'd3) idx_v = bump(idx_v);
        if (sector == 3'd3 || sector == 3'd4 || sector == 3'd5) idx_u = bump(idx_u);
        held_w = scaled(idx_w);
        held_v = scaled(idx_v);
        held_u = scaled(idx_u);
      end
      r.w      = held_w;
      r.v      = held_v;
      r.u      = held_u;
      r.sector = sector;
      expected_duties.push_back(r);
    endfunction

    function void compare_field(string name, int exp_val, int act_val);
      if (exp_val != act_val) begin
        $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, exp_val, act_val);
        mismatches++;
      end
    endfunction

    function void check_result(duty_result_t act);
      duty_result_t exp_r;
      if (expected_duties.size() == 0) begin
        $display("%0t: result with no request pending, got w=%0d v=%0d u=%0d",
                 $time, act.w, act.v, act.u);
        mismatches++;
        return;
      end
      exp_r = expected_duties.pop_front();
      compare_field("duty_w", exp_r.w, act.w);
      compare_field("duty_v", exp_r.v, act.v);
      compare_field("duty_u", exp_r.u, act.u);
      compare_field("stepped", exp_r.stepped, act.stepped);
      compare_field("sector_now", exp_r.sector, act.sector);
    endfunction

    function int pending();
      return expected_duties.size();
    endfunction
  endclass

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic [PERIOD_W-1:0] speed_period = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [DUTY_W-1:0]   duty_w;
  logic [DUTY_W-1:0]   duty_v;
  logic [DUTY_W-1:0]   duty_u;
  logic                stepped;
  logic [SECTOR_W-1:0] sector_now;
  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [PADDR_W-1:0]  paddr = '0;
  logic [PDATA_W-1:0]  pwdata = '0;
  logic [PDATA_W-1:0]  prdata;
  logic                pready;

  sine_duty_predictor predictor = new();
  int burst_left    = 1;
  int run_left      = 0;
  int run_kind      = 0;
  int run_period    = 0;
  int settings_used = 0;
  int results_seen  = 0;
  int hold_left     = 0;
  bit long_hold_done = 1'b0;
  int stall_phase   = 0;
  int idle_cycles   = 0;

  three_phase_sine_duty_generator u_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .speed_period(speed_period),
    .out_valid(out_valid), .out_stall(out_stall),
    .duty_w(duty_w), .duty_v(duty_v), .duty_u(duty_u),
    .stepped(stepped), .sector_now(sector_now),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #2 clk = ~clk;

  // Offer one tick request and wait for it; bursts may end in a random gap.
  task automatic send_tick(input logic [PERIOD_W-1:0] period);
    int gap;
    in_valid     <= 1'b1;
    speed_period <= period;
    do @(posedge clk); while (in_stall);
    predictor.note_tick(period);
    burst_left--;
    if (burst_left <= 0) begin
      burst_left = ($urandom_range(0, 4) == 0) ? 40 : $urandom_range(1, 16);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // Periods come in runs: mostly fast stepping, some slow or held stretches.
  function automatic logic [PERIOD_W-1:0] next_period();
    if (run_left == 0) begin
      run_kind   = $urandom_range(0, 19);
      run_left   = (run_kind >= 18) ? $urandom_range(5, 30) : $urandom_range(1, 12);
      run_period = $urandom_range(0, 255);
    end
    run_left--;
    if (run_kind < 11) return '0;
    if (run_kind < 15) return PERIOD_W'($urandom_range(1, 7));
    if (run_kind < 18) return PERIOD_W'($urandom_range(0, 255));
    return PERIOD_W'(run_period);
  endfunction

  task automatic wait_idle();
    while (predictor.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Write the amplitude register, then read it back.
  task automatic write_amplitude(input logic [AMP_W-1:0] value);
    logic [PDATA_W-1:0] readback;
    wait_idle();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_AMPLITUDE;
    pwdata  <= PDATA_W'(value);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    predictor.amplitude = value;
    settings_used++;
    pwrite  <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    readback = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    if (readback !== PDATA_W'(value)) begin
      $display("%0t: amplitude readback mismatch, expected %0d, got %0d",
               $time, value, readback);
      predictor.mismatches++;
    end
  endtask

  task automatic random_phase(input logic [AMP_W-1:0] amp);
    write_amplitude(amp);
    for (int i = 0; i < RANDOM_PER_PHASE; i++) begin
      send_tick(next_period());
    end
    in_valid <= 1'b0;
  endtask

  // Result side: check every accepted result, stall on a pattern of its own,
  // and hold off once for a long stretch so that the block backs up.
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      predictor.check_result('{duty_w, duty_v, duty_u, stepped, sector_now});
      results_seen++;
    end
    stall_phase++;
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (!long_hold_done && results_seen >= 150) begin
      long_hold_done = 1'b1;
      hold_left      = LONG_HOLD_CYCLES;
      out_stall     <= 1'b1;
    end else if ((stall_phase / 64) % 2 == 0) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(0, 2) == 0);
    end
  end

  // Watchdog on cycles where no handshake of any kind completes.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (psel && penable)) begin
      idle_cycles = 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no handshake for %0d cycles", $time, idle_cycles);
      $display("CHECKS FAILED");
      $finish;
    end else begin
      idle_cycles++;
    end
  end

  initial begin
    logic [PERIOD_W-1:0] directed_periods [16];
    directed_periods = '{8'd255, 8'd255, 8'd255, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0,
                         8'd0, 8'd1, 8'd1, 8'd1, 8'd1, 8'd2, 8'd2, 8'd2};
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Duties stay zero before the first step, then zero periods step every tick.
    foreach (directed_periods[i]) send_tick(directed_periods[i]);
    in_valid <= 1'b0;

    // Zero amplitude clears all duties at the next step.
    write_amplitude(8'd0);
    for (int i = 0; i < 4; i++) send_tick(8'd0);
    send_tick(8'd255);
    in_valid <= 1'b0;

    random_phase(8'd1);
    random_phase(AMP_W'($urandom_range(2, 254)));
    random_phase(8'd128);
    random_phase(8'd255);
    random_phase(AMP_W'($urandom_range(0, 255)));

    wait_idle();
    repeat (8) @(posedge clk);
    $display("Covered %0d ticks with %0d sector steps over %0d amplitude settings,",
             predictor.ticks, predictor.steps, settings_used);
    $display("including zero, one and full scale amplitude and a long result hold-off.");
    if (predictor.mismatches == 0 && predictor.pending() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
